@@ src/albu_pkg.sv @@
// Shared constants for the ambient light auto-brightness unit.
// Field widths, reset values, and configuration register indexes.
// No dependencies.
package albu_pkg;

  localparam int LUX_W = 24;   // Q16.8 light value
  localparam int LVL_W = 16;   // Q8.8 brightness percent
  localparam int CFG_W = 16;   // widest configuration register
  localparam int SHIFT_W = 3;  // ramp_shift width
  localparam int ADDR_W = 3;   // configuration index width
  localparam int STEP_W = 17;  // signed fade step
  localparam int LOG_W = 13;   // signed Q5.8 log2 value

  localparam int WINDOW_DEPTH_DEF = 10;

  localparam logic [LUX_W-1:0] LIGHT_RESET = 24'd1280;   // 5.0
  localparam logic [LVL_W-1:0] LEVEL_RESET = 16'd12800;  // 50 percent

  // Configuration register indexes
  localparam logic [ADDR_W-1:0] REG_LOG_GAIN    = 3'd0;
  localparam logic [ADDR_W-1:0] REG_LOG_OFFSET  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_MIN_AVERAGE = 3'd2;
  localparam logic [ADDR_W-1:0] REG_SNAP_WINDOW = 3'd3;
  localparam logic [ADDR_W-1:0] REG_MIN_DRIVE   = 3'd4;
  localparam logic [ADDR_W-1:0] REG_RAMP_SHIFT  = 3'd5;

  // Configuration reset values
  localparam logic [CFG_W-1:0]   LOG_GAIN_RESET    = 16'd1762;
  localparam logic [CFG_W-1:0]   LOG_OFFSET_RESET  = 16'd6927;
  localparam logic [CFG_W-1:0]   MIN_AVERAGE_RESET = 16'd38;
  localparam logic [CFG_W-1:0]   SNAP_WINDOW_RESET = 16'd192;
  localparam logic [CFG_W-1:0]   MIN_DRIVE_RESET   = 16'd512;
  localparam logic [SHIFT_W-1:0] RAMP_SHIFT_RESET  = 3'd3;

  // Item kinds carried on s_tuser
  localparam logic REQ_READING = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

endpackage

@@ src/ambient_light_auto_brightness_unit.sv @@
// Ambient light auto-brightness unit: moving average, Mitchell log2 target,
// stepped fade toward the target. Depends on albu_pkg.
//
// A reading item steps through SUM, DIV, FLOOR, NORM, MUL, TGT, STEP and FIN;
//   NORM repeats for each normalize shift, set by the leading-one position of the
//   floored average. A fade tick passes TICK, SNAP and FIN; a tick while idle only FIN.
// One item at a time: s_tready is high only while the sequencer idles, from the
// cycle in which the result turns valid; a finished result waits in the output
// register while the next item is taken, and a stalled result holds the sequencer.
// Reset (rst, synchronous, active high) loads the window with 5.0, level 50%,
// target 0, no fade, and the register defaults.
module ambient_light_auto_brightness_unit #(
  parameter int WINDOW_DEPTH = albu_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [albu_pkg::LUX_W-1:0]      s_tdata,   // [23:0] lux_reading
  input  logic [0:0]                      s_tuser,   // [0] req_type
  // Result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [2*albu_pkg::LVL_W-1:0]    m_tdata,   // [15:0] drive_level, [31:16] target_level
  output logic [1:0]                      m_tuser,   // [0] drive_update, [1] fading
  // Configuration writes
  input  logic                            cfg_we,
  input  logic [albu_pkg::ADDR_W-1:0]     cfg_addr,
  input  logic [albu_pkg::CFG_W-1:0]      cfg_wdata
);

  import albu_pkg::*;

  // Running sum needs room for WINDOW_DEPTH full-scale readings.
  localparam int SUM_W = LUX_W + $clog2(WINDOW_DEPTH);
  localparam int POS_W = $clog2(LUX_W);
  localparam int PROD_W = LVL_W + 1 + LOG_W;

  // Divide the sum by WINDOW_DEPTH with a rounded-up reciprocal: exact for
  // every SUM_W-bit sum when the shift is SUM_W + clog2(WINDOW_DEPTH)
  localparam int RECIP_SH = SUM_W + $clog2(WINDOW_DEPTH);
  localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(((64'd1 << RECIP_SH) +
    64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(LIGHT_RESET) * SUM_W'(WINDOW_DEPTH);

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SUM   = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_FLOOR = 4'd3;
  localparam logic [3:0] ST_NORM  = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_TGT   = 4'd6;
  localparam logic [3:0] ST_STEP  = 4'd7;
  localparam logic [3:0] ST_TICK  = 4'd8;
  localparam logic [3:0] ST_SNAP  = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0] state;

  // Configuration registers
  logic [CFG_W-1:0]          log_gain;
  logic signed [CFG_W-1:0]   log_offset;
  logic [CFG_W-1:0]          min_average;
  logic [CFG_W-1:0]          snap_window;
  logic [CFG_W-1:0]          min_drive;
  logic [SHIFT_W-1:0]        ramp_shift;

  // Block state
  logic [LUX_W-1:0]          light_window [WINDOW_DEPTH];
  logic [SUM_W-1:0]          window_sum;
  logic [LVL_W-1:0]          current_level;
  logic [LVL_W-1:0]          goal_level;
  logic signed [STEP_W-1:0]  fade_step;
  logic                      fade_active;
  logic                      drive_update;

  // Working registers of the shared datapath
  logic [LUX_W-1:0]          lux;
  logic [SUM_W-1:0]          quo;
  logic [LUX_W-1:0]          norm;
  logic [POS_W-1:0]          pos;
  logic signed [PROD_W-1:0]  prod;
  logic [LVL_W-1:0]          lvl_sat;

  // Sum times reciprocal; the average sits at bit RECIP_SH
  logic [2*SUM_W:0] avg_prod;
  assign avg_prod = (2*SUM_W+1)'(quo) * (2*SUM_W+1)'(RECIP);

  // Average floored at min_average, and at one LSB so log2 is defined
  logic [LUX_W-1:0] avg_floor;
  always_comb begin
    avg_floor = quo[LUX_W-1:0];
    if (avg_floor < LUX_W'(min_average)) begin
      avg_floor = LUX_W'(min_average);
    end
    if (avg_floor == '0) begin
      avg_floor = LUX_W'(1);
    end
  end

  // Mitchell log2: integer part is leading-one position minus 8, fraction is
  // the 8 bits right below the leading one
  logic signed [LOG_W-1:0] log_val;
  logic signed [5:0]       pos_m8;
  assign pos_m8 = $signed({1'b0, pos}) - 6'sd8;
  assign log_val = {pos_m8[4:0], norm[LUX_W-2 -: 8]};

  // Target: floor(gain * log2 / 256) + offset, saturated to 0..65535
  logic signed [PROD_W-9:0] scaled;
  logic signed [PROD_W-8:0] tgt_sum;
  logic [LVL_W-1:0]         tgt_sat;
  always_comb begin
    scaled  = prod[PROD_W-1:8];
    tgt_sum = $signed({scaled[PROD_W-9], scaled}) + (PROD_W-7)'(log_offset);
    if (tgt_sum < 0) begin
      tgt_sat = '0;
    end else if (tgt_sum > $signed((PROD_W-7)'(16'hFFFF))) begin
      tgt_sat = '1;
    end else begin
      tgt_sat = tgt_sum[LVL_W-1:0];
    end
  end

  // Fade step: |diff| >> ramp_shift, at least one, sign of diff
  logic signed [STEP_W-1:0] diff;
  logic [STEP_W-1:0]        mag;
  logic [STEP_W-1:0]        mag_sh;
  logic signed [STEP_W-1:0] step_new;
  always_comb begin
    diff   = $signed({1'b0, goal_level}) - $signed({1'b0, current_level});
    mag    = diff[STEP_W-1] ? STEP_W'(-diff) : STEP_W'(diff);
    mag_sh = mag >> ramp_shift;
    if (mag_sh == '0) begin
      mag_sh = STEP_W'(1);
    end
    step_new = diff[STEP_W-1] ? -$signed(mag_sh) : $signed(mag_sh);
  end

  // Tick: level + step saturated to 0..65535
  logic signed [STEP_W:0] lvl_add;
  logic [LVL_W-1:0]       lvl_add_sat;
  always_comb begin
    lvl_add = $signed({2'b00, current_level}) + $signed({fade_step[STEP_W-1], fade_step});
    if (lvl_add < 0) begin
      lvl_add_sat = '0;
    end else if (lvl_add > $signed((STEP_W+1)'(16'hFFFF))) begin
      lvl_add_sat = '1;
    end else begin
      lvl_add_sat = lvl_add[LVL_W-1:0];
    end
  end

  // Snap when the stepped level lands within snap_window of the target
  logic signed [STEP_W-1:0] snap_gap_s;
  logic [STEP_W-1:0]        snap_gap;
  logic [LVL_W-1:0]         lvl_new;
  always_comb begin
    snap_gap_s = $signed({1'b0, lvl_sat}) - $signed({1'b0, goal_level});
    snap_gap   = snap_gap_s[STEP_W-1] ? STEP_W'(-snap_gap_s) : STEP_W'(snap_gap_s);
    lvl_new    = (snap_gap < STEP_W'(snap_window)) ? goal_level : lvl_sat;
  end

  logic [LVL_W-1:0] drive;
  assign drive = (current_level < min_drive) ? min_drive : current_level;

  assign s_tready = (state == ST_IDLE);

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      log_gain    <= LOG_GAIN_RESET;
      log_offset  <= LOG_OFFSET_RESET;
      min_average <= MIN_AVERAGE_RESET;
      snap_window <= SNAP_WINDOW_RESET;
      min_drive   <= MIN_DRIVE_RESET;
      ramp_shift  <= RAMP_SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LOG_GAIN:    log_gain    <= cfg_wdata;
        REG_LOG_OFFSET:  log_offset  <= cfg_wdata;
        REG_MIN_AVERAGE: min_average <= cfg_wdata;
        REG_SNAP_WINDOW: snap_window <= cfg_wdata;
        REG_MIN_DRIVE:   min_drive   <= cfg_wdata;
        REG_RAMP_SHIFT:  ramp_shift  <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Light window: shift line, advanced once per reading
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        light_window[i] <= LIGHT_RESET;
      end
    end else if (state == ST_SUM) begin
      light_window[0] <= lux;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        light_window[i] <= light_window[i-1];
      end
    end
  end

  // Working registers carry no reset
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        lux <= s_tdata;
      end
      ST_SUM: begin
        // Load the updated sum for the reciprocal multiply
        quo <= window_sum - SUM_W'(light_window[WINDOW_DEPTH-1]) + SUM_W'(lux);
      end
      ST_DIV: begin
        quo <= SUM_W'(avg_prod[RECIP_SH +: LUX_W]);
      end
      ST_FLOOR: begin
        norm <= avg_floor;
        pos  <= POS_W'(LUX_W - 1);
      end
      ST_NORM: begin
        if (!norm[LUX_W-1] && pos != '0) begin
          norm <= {norm[LUX_W-2:0], 1'b0};
          pos  <= pos - POS_W'(1);
        end
      end
      ST_MUL: begin
        prod <= $signed({1'b0, log_gain}) * log_val;
      end
      ST_TICK: begin
        lvl_sat <= lvl_add_sat;
      end
      default: ;
    endcase
  end

  // Sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_sum    <= SUM_RESET;
      current_level <= LEVEL_RESET;
      goal_level    <= '0;
      fade_step     <= '0;
      fade_active   <= 1'b0;
      drive_update  <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // Load a finished result, or drop the one just taken
      if (state == ST_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            drive_update <= 1'b0;
            if (s_tuser[0] == REQ_READING) begin
              state <= ST_SUM;
            end else if (fade_active) begin
              state <= ST_TICK;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_SUM: begin
          window_sum <= window_sum - SUM_W'(light_window[WINDOW_DEPTH-1]) + SUM_W'(lux);
          state      <= ST_DIV;
        end
        ST_DIV: state <= ST_FLOOR;
        ST_FLOOR: state <= ST_NORM;
        ST_NORM: begin
          if (norm[LUX_W-1] || pos == '0) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_TGT;
        ST_TGT: begin
          goal_level <= tgt_sat;
          state      <= ST_STEP;
        end
        ST_STEP: begin
          // Equal target leaves step and fade flag as they were
          if (goal_level != current_level) begin
            fade_step   <= step_new;
            fade_active <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_TICK: state <= ST_SNAP;
        ST_SNAP: begin
          current_level <= lvl_new;
          fade_active   <= (lvl_new != goal_level);
          drive_update  <= 1'b1;
          state         <= ST_FIN;
        end
        ST_FIN: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {goal_level, drive};
      m_tuser <= {fade_active, drive_update};
    end
  end

endmodule

@@ src/albu_checker.sv @@
// Port-level checks for the ambient light auto-brightness unit.
// Bound to ambient_light_auto_brightness_unit; depends on albu_pkg.
module albu_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [2*albu_pkg::LVL_W-1:0]   m_tdata,
  input logic [1:0]                     m_tuser
);

  // No result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // One item at a time: busy in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted item");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // A tick that ends the fade leaves the level on target, so drive >= target
  a_fade_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] && !m_tuser[1]) |-> (m_tdata[15:0] >= m_tdata[31:16]))
    else $error("fade ended below target");

endmodule

bind ambient_light_auto_brightness_unit albu_checker u_albu_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ambient_light_auto_brightness_unit: directed and random
// light readings and fade ticks, every result compared with a local brightness model
// or a value typed in by hand. Depends on albu_pkg and the unit's RTL; reads no files.
module tb;
  import albu_pkg::*;

  localparam int DEPTH           = WINDOW_DEPTH_DEF;
  localparam int SUM_BITS        = LUX_W + $clog2(DEPTH);
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 153;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 80;     // longer than the slowest reading
  localparam int REPORT_MAX      = 10;
  localparam logic [LUX_W-1:0] LUX_MAX = '1;

  localparam logic [ADDR_W-1:0] REG_LIST [6] = '{REG_LOG_GAIN, REG_LOG_OFFSET,
    REG_MIN_AVERAGE, REG_SNAP_WINDOW, REG_MIN_DRIVE, REG_RAMP_SHIFT};

  // One result item, fields in the order they are compared
  typedef struct packed {
    logic [LVL_W-1:0] drive;
    logic             update;
    logic [LVL_W-1:0] target;
    logic             fading;
  } backlight_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed plan: either an item or a register write
  typedef struct {
    row_kind_t        kind;
    logic             req;
    logic [ADDR_W-1:0] reg_idx;
    logic [LUX_W-1:0] value;
    bit               has_want;
    backlight_t       want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [LUX_W-1:0]   s_tdata = '0;     // [23:0] lux_reading
  logic [0:0]         s_tuser = '0;     // [0] req_type
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [2*LVL_W-1:0] m_tdata;          // [15:0] drive_level, [31:16] target_level
  logic [1:0]         m_tuser;          // [0] drive_update, [1] fading
  logic               cfg_we = 1'b0;
  logic [ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  ambient_light_auto_brightness_unit #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Brightness model: light history, fade state and its own register copies
  // ---------------------------------------------------------------------------
  logic [LUX_W-1:0]        light_hist [DEPTH];
  logic [SUM_BITS-1:0]     light_sum;
  int                      level_now;
  int                      level_goal;
  int                      level_step;
  bit                      fade_on;
  logic [CFG_W-1:0]        gain_r;
  logic signed [CFG_W-1:0] offset_r;
  logic [CFG_W-1:0]        min_avg_r;
  logic [CFG_W-1:0]        snap_r;
  logic [CFG_W-1:0]        min_drv_r;
  logic [SHIFT_W-1:0]      shift_r;

  backlight_t backlight_q[$];   // results still owed by the unit
  backlight_t seen;
  backlight_t owed;
  int         fail_count = 0;
  int         cycle_count = 0;
  int         sent_count = 0;
  int         recv_count = 0;
  bit         send_calm = 1'b0;
  bit         recv_calm = 1'b0;
  plan_row_t  plan[$];

  // Mitchell log2: integer part from the leading one, the next 8 bits as fraction.
  // A zero average is treated as one LSB.
  function automatic int mitchell_log2(input logic [LUX_W-1:0] v);
    int p;
    logic [LUX_W-1:0] mant;
    int frac;
    if (v == '0) v = LUX_W'(1);
    p = LUX_W - 1;
    while (p > 0 && v[p] == 1'b0) p--;
    mant = v - (24'd1 << p);
    frac = (p >= 8) ? int'(mant >> (p - 8)) : int'(mant << (8 - p));
    return (p - 8) * 256 + (frac & 255);
  endfunction

  // gain * log2 rounded toward minus infinity, plus offset, clamped to 16 bits
  function automatic int light_to_target(input logic [LUX_W-1:0] avg);
    longint prod;
    longint t;
    prod = longint'(gain_r) * longint'(mitchell_log2(avg));
    t = (prod >>> 8) + longint'(offset_r);
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return int'(t);
  endfunction

  // Advance the model by one accepted item and return the result it owes
  function automatic backlight_t predict_backlight(input logic req, input logic [LUX_W-1:0] lux);
    backlight_t res;
    logic [SUM_BITS-1:0] avg;
    int diff;
    int mag;
    int lvl;
    int gap_to_goal;
    res.update = 1'b0;
    if (req == REQ_READING) begin
      light_sum = light_sum - SUM_BITS'(light_hist[DEPTH-1]);
      for (int i = DEPTH - 1; i > 0; i--) light_hist[i] = light_hist[i-1];
      light_hist[0] = lux;
      light_sum = light_sum + SUM_BITS'(lux);
      avg = light_sum / SUM_BITS'(DEPTH);
      if (avg < SUM_BITS'(min_avg_r)) avg = SUM_BITS'(min_avg_r);
      level_goal = light_to_target(avg[LUX_W-1:0]);
      // a target equal to the level leaves the fade as it was
      if (level_goal != level_now) begin
        diff = level_goal - level_now;
        mag = (diff < 0 ? -diff : diff) >> shift_r;
        if (mag == 0) mag = 1;
        level_step = (diff < 0) ? -mag : mag;
        fade_on = 1'b1;
      end
    end else if (fade_on) begin
      lvl = level_now + level_step;
      if (lvl < 0) lvl = 0;
      if (lvl > 65535) lvl = 65535;
      gap_to_goal = lvl - level_goal;
      if (gap_to_goal < 0) gap_to_goal = -gap_to_goal;
      if (gap_to_goal < int'(snap_r)) lvl = level_goal;
      level_now = lvl;
      fade_on = (level_now != level_goal);
      res.update = 1'b1;
    end
    res.drive = (level_now < int'(min_drv_r)) ? min_drv_r : level_now[LVL_W-1:0];
    res.target = level_goal[LVL_W-1:0];
    res.fading = fade_on;
    return res;
  endfunction

  function automatic void apply_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_LOG_GAIN:    gain_r = val;
      REG_LOG_OFFSET:  offset_r = val;
      REG_MIN_AVERAGE: min_avg_r = val;
      REG_SNAP_WINDOW: snap_r = val;
      REG_MIN_DRIVE:   min_drv_r = val;
      REG_RAMP_SHIFT:  shift_r = val[SHIFT_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan rows
  // ---------------------------------------------------------------------------
  function automatic plan_row_t item_row(input logic req, input logic [LUX_W-1:0] lux);
    plan_row_t row;
    row.kind = ROW_ITEM;
    row.req = req;
    row.reg_idx = '0;
    row.value = lux;
    row.has_want = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t checked_row(input logic req, input logic [LUX_W-1:0] lux,
                                            input int drive, input bit upd,
                                            input int target, input bit fading);
    plan_row_t row;
    row = item_row(req, lux);
    row.has_want = 1'b1;
    row.want = '{drive[LVL_W-1:0], upd, target[LVL_W-1:0], fading};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row = item_row(REQ_READING, '0);
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.value = LUX_W'(val);
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------
  // Mostly readings near the phase's room light so the average settles and
  // fades run to the end; the rest are extremes, very dim or anywhere.
  function automatic logic [LUX_W-1:0] pick_lux(input int room);
    int spread;
    int lux;
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? LUX_MAX : '0;
      1: return LUX_W'($urandom_range(0, 255));
      2: return LUX_W'($urandom_range(0, 24'hFFFFFF));
      default: begin
        spread = room / 8;
        lux = room - spread + int'($urandom_range(0, 2 * spread));
        if (lux < 0) lux = 0;
        if (lux > 24'hFFFFFF) lux = 24'hFFFFFF;
        return lux[LUX_W-1:0];
      end
    endcase
  endfunction

  // Zero, all ones, reset value, any bit pattern, or a value a product would use
  function automatic logic [CFG_W-1:0] pick_reg_value(input logic [ADDR_W-1:0] idx);
    logic [CFG_W-1:0] top;
    logic [CFG_W-1:0] dflt;
    logic [CFG_W-1:0] usual;
    top = '1;
    case (idx)
      REG_LOG_GAIN: begin
        dflt = LOG_GAIN_RESET;    usual = CFG_W'($urandom_range(300, 4000));
      end
      REG_LOG_OFFSET: begin
        dflt = LOG_OFFSET_RESET;  usual = CFG_W'($urandom_range(0, 20000));
      end
      REG_MIN_AVERAGE: begin
        dflt = MIN_AVERAGE_RESET; usual = CFG_W'($urandom_range(0, 2000));
      end
      REG_SNAP_WINDOW: begin
        dflt = SNAP_WINDOW_RESET; usual = CFG_W'($urandom_range(0, 1024));
      end
      REG_MIN_DRIVE: begin
        dflt = MIN_DRIVE_RESET;   usual = CFG_W'($urandom_range(0, 8000));
      end
      default: begin
        // ramp shift: three bits only
        top = 16'd7;
        dflt = CFG_W'(RAMP_SHIFT_RESET);
        usual = CFG_W'($urandom_range(0, 7));
      end
    endcase
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return top;
      2:       return dflt;
      3:       return CFG_W'($urandom) & top;
      default: return usual;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------
  // Present one item after a random gap, hold it until taken, then log the
  // result it owes (typed in by hand for some directed rows).
  task automatic send_item(input logic req, input logic [LUX_W-1:0] lux,
                           input bit has_want, input backlight_t want);
    int gap;
    backlight_t predicted;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= lux;
    do @(posedge clk); while (!s_tready);
    predicted = predict_backlight(req, lux);
    backlight_q.push_back(has_want ? want : predicted);
    sent_count++;
    // switch between gappy and back-to-back stretches now and then
    if (sent_count % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed result is back: every item yields
  // one result, so the unit is idle once the queue drains.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (backlight_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls before each result, calm stretches between
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      recv_count++;
      if (recv_count % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest owed one
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = {m_tdata[LVL_W-1:0], m_tuser[0], m_tdata[2*LVL_W-1:LVL_W], m_tuser[1]};
      if (backlight_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("result with nothing owed: drive %0d update %0d target %0d fading %0d",
                   seen.drive, seen.update, seen.target, seen.fading);
      end else begin
        owed = backlight_q.pop_front();
        if (seen !== owed) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: drive %0d/%0d update %0d/%0d target %0d/%0d fading %0d/%0d",
                     owed.drive, seen.drive, owed.update, seen.update,
                     owed.target, seen.target, owed.fading, seen.fading);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int room;

    for (int i = 0; i < DEPTH; i++) light_hist[i] = LIGHT_RESET;
    light_sum = SUM_BITS'(LIGHT_RESET * DEPTH);
    level_now = int'(LEVEL_RESET);
    level_goal = 0;
    level_step = 0;
    fade_on = 1'b0;
    gain_r = LOG_GAIN_RESET;
    offset_r = LOG_OFFSET_RESET;
    min_avg_r = MIN_AVERAGE_RESET;
    snap_r = SNAP_WINDOW_RESET;
    min_drv_r = MIN_DRIVE_RESET;
    shift_r = RAMP_SHIFT_RESET;

    // Directed plan. Tick right after reset does nothing: level 50%, target 0.
    plan.push_back(checked_row(REQ_TICK, 24'h00ABCD, 12800, 1'b0, 0, 1'b0));
    // Zero gain makes the target the offset alone; an offset equal to the
    // level gives a target equal to the level, so no fade starts.
    plan.push_back(cfg_row(REG_LOG_GAIN, 16'h0000));
    plan.push_back(cfg_row(REG_LOG_OFFSET, 16'd12800));
    plan.push_back(checked_row(REQ_READING, LUX_MAX, 12800, 1'b0, 12800, 1'b0));
    plan.push_back(checked_row(REQ_TICK, 24'h000000, 12800, 1'b0, 12800, 1'b0));
    // Most negative offset clamps the target to 0 and starts a fade down
    plan.push_back(cfg_row(REG_LOG_OFFSET, 16'h8000));
    plan.push_back(checked_row(REQ_READING, 24'h000000, 12800, 1'b0, 0, 1'b1));
    plan.push_back(item_row(REQ_TICK, LUX_MAX));
    // Highest drive floor hides the level
    plan.push_back(cfg_row(REG_MIN_DRIVE, 16'hFFFF));
    plan.push_back(checked_row(REQ_TICK, 24'h000000, 65535, 1'b1, 0, 1'b1));
    // Largest gain and offset push the target to full scale; slowest ramp,
    // no snap window
    plan.push_back(cfg_row(REG_LOG_GAIN, 16'hFFFF));
    plan.push_back(cfg_row(REG_LOG_OFFSET, 16'h7FFF));
    plan.push_back(cfg_row(REG_MIN_DRIVE, 16'h0000));
    plan.push_back(cfg_row(REG_RAMP_SHIFT, 16'd7));
    plan.push_back(cfg_row(REG_SNAP_WINDOW, 16'h0000));
    plan.push_back(item_row(REQ_READING, LUX_MAX));
    repeat (3) plan.push_back(item_row(REQ_TICK, 24'h5A5A5A));
    // No shift: one tick lands exactly on the target, the next finds it idle
    plan.push_back(cfg_row(REG_RAMP_SHIFT, 16'd0));
    plan.push_back(item_row(REQ_READING, 24'h000001));
    repeat (2) plan.push_back(item_row(REQ_TICK, 24'hA5A5A5));
    // No average floor: a window full of darkness needs the one-LSB log input
    plan.push_back(cfg_row(REG_MIN_AVERAGE, 16'h0000));
    plan.push_back(cfg_row(REG_LOG_GAIN, LOG_GAIN_RESET));
    plan.push_back(cfg_row(REG_LOG_OFFSET, LOG_OFFSET_RESET));
    plan.push_back(cfg_row(REG_RAMP_SHIFT, CFG_W'(RAMP_SHIFT_RESET)));
    plan.push_back(cfg_row(REG_SNAP_WINDOW, SNAP_WINDOW_RESET));
    repeat (DEPTH) plan.push_back(item_row(REQ_READING, 24'h000000));
    // Dim average with its leading one below the binary point
    plan.push_back(item_row(REQ_READING, 24'h000080));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].value[CFG_W-1:0]);
      end else begin
        send_item(plan[i].req, plan[i].value, plan[i].has_want, plan[i].want);
      end
    end

    // Random phases: new settings while idle, a room light level spanning
    // many decades, then readings each followed on average by a few ticks
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      foreach (REG_LIST[r])
        if (ph == 0 || $urandom_range(0, 2) != 0)
          write_reg(REG_LIST[r], pick_reg_value(REG_LIST[r]));
      room = $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16);
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 30)
          send_item(REQ_READING, pick_lux(room), 1'b0, '0);
        else
          send_item(REQ_TICK, LUX_W'($urandom_range(0, 24'hFFFFFF)), 1'b0, '0);
      end
    end

    // Drain, then give the unit time to show any stray result
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && backlight_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ ambient_light_auto_brightness_unit.f @@
src/albu_pkg.sv
src/ambient_light_auto_brightness_unit.sv
src/albu_checker.sv
tb/sv/tb.sv
